// ===== rtl/i2p_pkg.sv =====
package i2p_pkg;

  // Default operator stack depth
  localparam int unsigned StackDepthDef = 32;

  // Operator codes as kept on the stack
  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_POW    = 3'd5
  } op_code_e;

  // Character classes
  typedef enum logic [2:0] {
    KIND_OPND,
    KIND_LPAR,
    KIND_RPAR,
    KIND_OPER,
    KIND_OTHER
  } char_kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_PUSH,
    ST_CLOSE,
    ST_OPER,
    ST_FLUSH
  } state_e;

  localparam logic [7:0] ChLParen = 8'h28;  // '('
  localparam logic [7:0] ChRParen = 8'h29;  // ')'
  localparam logic [7:0] ChMul    = 8'h2A;  // '*'
  localparam logic [7:0] ChAdd    = 8'h2B;  // '+'
  localparam logic [7:0] ChSub    = 8'h2D;  // '-'
  localparam logic [7:0] ChDiv    = 8'h2F;  // '/'
  localparam logic [7:0] ChPow    = 8'h5E;  // '^'

  // Stack command from the sequencer
  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_e code;
  } stk_cmd_t;

  // Stack status toward the sequencer
  typedef struct packed {
    logic     empty;
    logic     full;
    logic     one;        // exactly one entry
    logic     two;        // exactly two entries
    logic     paren_one;  // exactly one '(' stacked
    op_code_e top;
  } stk_stat_t;

  // One result item
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       has_char;
    logic       last;
    logic       overflow;
  } res_t;

  function automatic char_kind_e char_kind(input logic [7:0] ch);
    char_kind_e k;
    if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
        (ch >= 8'h30 && ch <= 8'h39)) begin
      k = KIND_OPND;
    end else if (ch == ChLParen) begin
      k = KIND_LPAR;
    end else if (ch == ChRParen) begin
      k = KIND_RPAR;
    end else if (ch == ChAdd || ch == ChSub || ch == ChMul || ch == ChDiv ||
                 ch == ChPow) begin
      k = KIND_OPER;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

  function automatic op_code_e char_to_op(input logic [7:0] ch);
    op_code_e c;
    case (ch)
      ChAdd:   c = OP_ADD;
      ChSub:   c = OP_SUB;
      ChMul:   c = OP_MUL;
      ChDiv:   c = OP_DIV;
      ChPow:   c = OP_POW;
      default: c = OP_LPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] op_to_char(input op_code_e c);
    logic [7:0] ch;
    case (c)
      OP_LPAREN: ch = ChLParen;
      OP_ADD:    ch = ChAdd;
      OP_SUB:    ch = ChSub;
      OP_MUL:    ch = ChMul;
      OP_DIV:    ch = ChDiv;
      OP_POW:    ch = ChPow;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] op_prec(input op_code_e c);
    logic [1:0] p;
    case (c)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/infix_to_postfix.sv =====
// Infix to postfix converter (shunting-yard).
// Input stream: one ASCII character per item on s_axis_tdata; s_axis_tlast
// marks the final character of an expression. Output stream: postfix
// characters on m_axis_tdata, m_axis_tlast on the final result of each
// expression, m_axis_tuser = {overflow, has_char}. An expression with no
// output yields one result with has_char low and tlast high.
// The block takes one item at a time: s_axis_tready is high only while the
// sequencer is idle. An ignored character is dropped on accept; an operand
// is accepted, then emitted; a '(' is accepted, then pushed; a ')' pops one
// entry per step; an operator is accepted, compared with the top and popped
// step by step, then pushed. The end flush pops each stacked entry, or emits
// an end marker when nothing was output. Each operator is pushed and popped
// at most once. The stack has a single port and the precedence compare is a
// single unit, one step each cycle while the receiver takes results.
// Results leave through an output register; a stalled receiver holds it and
// freezes the sequencer at its next result, and new input waits meanwhile.
// Reset empties the stack, clears the overflow flag and the output valid;
// stack entries and the output data register are not cleared.
module infix_to_postfix
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // end_of_expr
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,   // last
  output logic [1:0] m_axis_tuser    // [0] has_char, [1] overflow
);

  stk_cmd_t   cmd;
  stk_stat_t  stat;
  res_t       res;
  logic       out_free;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic [1:0] user_q;

  assign out_free = !valid_q || m_axis_tready;

  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .out_free_i (out_free),
    .res_o      (res),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  i2p_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free) begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      char_q <= res.ch;
      last_q <= res.last;
      user_q <= {res.overflow, res.has_char};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = char_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

endmodule

// ===== rtl/i2p_stack.sv =====
module i2p_stack
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stk_cmd_t  cmd_i,
  output stk_stat_t stat_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  op_code_e          mem_q [STACK_DEPTH];
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   paren_q, paren_d;
  logic [CntW-1:0]   top_pos;
  logic              full;
  logic              do_push;
  op_code_e          top;

  assign top_pos = count_q - CntW'(1);
  assign top     = mem_q[top_pos[IdxW-1:0]];
  assign full    = (count_q == CntW'(STACK_DEPTH));
  // A push to a full stack is dropped
  assign do_push = cmd_i.push && !full;

  // Count and open-paren tally
  always_comb begin
    count_d = count_q;
    paren_d = paren_q;
    if (do_push) begin
      count_d = count_q + CntW'(1);
      if (cmd_i.code == OP_LPAREN) begin
        paren_d = paren_q + CntW'(1);
      end
    end else if (cmd_i.pop && count_q != '0) begin
      count_d = count_q - CntW'(1);
      if (top == OP_LPAREN) begin
        paren_d = paren_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      paren_q <= '0;
    end else begin
      count_q <= count_d;
      paren_q <= paren_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[count_q[IdxW-1:0]] <= cmd_i.code;
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = full;
  assign stat_o.one       = (count_q == CntW'(1));
  assign stat_o.two       = (count_q == CntW'(2));
  assign stat_o.paren_one = (paren_q == CntW'(1));
  assign stat_o.top       = top;

endmodule

// ===== rtl/i2p_ctrl.sv =====
module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_end_i,
  input  logic       out_free_i,
  output res_t       res_o,
  output stk_cmd_t   cmd_o,
  input  stk_stat_t  stat_i
);

  state_e     state_q, state_d;
  logic [7:0] char_q, char_d;
  logic       end_q, end_d;
  logic       emitted_q, emitted_d;
  logic       ovf_q, ovf_d;
  state_e     after_item;
  op_code_e   cur_op;
  logic [1:0] cur_prec, top_prec;
  logic       pop_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign after_item = end_q ? ST_FLUSH : ST_IDLE;

  // Precedence compare unit, used for the operator pop decision
  assign cur_op   = char_to_op(char_q);
  assign cur_prec = op_prec(cur_op);
  assign top_prec = op_prec(stat_i.top);
  assign pop_ok   = (cur_op == OP_POW) ? (top_prec > cur_prec) : (top_prec >= cur_prec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      emitted_q <= 1'b0;
      ovf_q     <= 1'b0;
      end_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      emitted_q <= emitted_d;
      ovf_q     <= ovf_d;
      end_q     <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    char_d    = char_q;
    end_d     = end_q;
    emitted_d = emitted_q;
    ovf_d     = ovf_q;
    res_o     = '0;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          char_d    = in_char_i;
          end_d     = in_end_i;
          emitted_d = 1'b0;
          unique case (char_kind(in_char_i))
            KIND_OPND: state_d = ST_OPND;
            KIND_LPAR: state_d = ST_PUSH;
            KIND_RPAR: state_d = ST_CLOSE;
            KIND_OPER: state_d = ST_OPER;
            default:   state_d = in_end_i ? ST_FLUSH : ST_IDLE;
          endcase
        end
      end
      ST_OPND: begin
        if (out_free_i) begin
          res_o.valid    = 1'b1;
          res_o.ch       = char_q;
          res_o.has_char = 1'b1;
          res_o.last     = end_q && stat_i.empty;
          res_o.overflow = res_o.last && ovf_q;
          emitted_d      = 1'b1;
          if (res_o.last) begin
            ovf_d = 1'b0;
          end
          state_d = after_item;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        cmd_o.code = (char_kind(char_q) == KIND_LPAR) ? OP_LPAREN : cur_op;
        if (stat_i.full) begin
          ovf_d = 1'b1;
        end
        state_d = after_item;
      end
      ST_CLOSE: begin
        if (stat_i.empty) begin
          state_d = after_item;
        end else if (stat_i.top == OP_LPAREN) begin
          // matching paren is dropped
          cmd_o.pop = 1'b1;
          state_d   = after_item;
        end else if (out_free_i) begin
          cmd_o.pop      = 1'b1;
          res_o.valid    = 1'b1;
          res_o.ch       = op_to_char(stat_i.top);
          res_o.has_char = 1'b1;
          // last when nothing but a bottom '(' remains below
          res_o.last     = end_q && (stat_i.one || (stat_i.two && stat_i.paren_one));
          res_o.overflow = res_o.last && ovf_q;
          emitted_d      = 1'b1;
          if (res_o.last) begin
            ovf_d = 1'b0;
          end
        end
      end
      ST_OPER: begin
        if (stat_i.empty || stat_i.top == OP_LPAREN || !pop_ok) begin
          state_d = ST_PUSH;
        end else if (out_free_i) begin
          // a push always follows, so this pop is never last
          cmd_o.pop      = 1'b1;
          res_o.valid    = 1'b1;
          res_o.ch       = op_to_char(stat_i.top);
          res_o.has_char = 1'b1;
          emitted_d      = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (stat_i.empty) begin
          if (!emitted_q) begin
            // empty end marker
            if (out_free_i) begin
              res_o.valid    = 1'b1;
              res_o.last     = 1'b1;
              res_o.overflow = ovf_q;
              ovf_d          = 1'b0;
              state_d        = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end else if (out_free_i) begin
          cmd_o.pop      = 1'b1;
          res_o.valid    = 1'b1;
          res_o.ch       = op_to_char(stat_i.top);
          res_o.has_char = 1'b1;
          res_o.last     = stat_i.one;
          res_o.overflow = res_o.last && ovf_q;
          emitted_d      = 1'b1;
          if (res_o.last) begin
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/i2p_checker.sv =====
module i2p_checker
  import i2p_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled result changed");

  // One item at a time: an end item or a '(' keeps the sequencer busy
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tdata == ChLParen)
      |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  // Empty marker is only the final result and carries a zero character
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("empty marker malformed");

  // Overflow is reported only on the final result
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("overflow on non-final result");

endmodule

bind infix_to_postfix i2p_checker u_i2p_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import i2p_pkg::*;

  localparam int unsigned StackDepth = StackDepthDef;

  // One expected postfix result
  typedef struct {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
    logic       overflow;
  } postfix_item_t;

  // Shunting-yard tracker: mirrors the operator stack and holds the
  // postfix characters still to come out of the block.
  class postfix_tracker;
    op_code_e      op_stack[StackDepth];
    int unsigned   depth;
    bit            ovf_seen;
    postfix_item_t postfix_q[$];
    int unsigned   n_errors;
    int unsigned   n_results;
    int unsigned   n_exprs;
    int unsigned   n_ovf_exprs;

    function bit is_operand(input logic [7:0] ch);
      return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") ||
             (ch >= "0" && ch <= "9");
    endfunction

    function bit oper_code(input logic [7:0] ch, output op_code_e code);
      code = OP_LPAREN;
      case (ch)
        ChAdd:   code = OP_ADD;
        ChSub:   code = OP_SUB;
        ChMul:   code = OP_MUL;
        ChDiv:   code = OP_DIV;
        ChPow:   code = OP_POW;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function int unsigned rank(input op_code_e code);
      case (code)
        OP_ADD, OP_SUB: return 1;
        OP_MUL, OP_DIV: return 2;
        OP_POW:         return 3;
        default:        return 0;
      endcase
    endfunction

    function logic [7:0] code_char(input op_code_e code);
      case (code)
        OP_ADD:  return ChAdd;
        OP_SUB:  return ChSub;
        OP_MUL:  return ChMul;
        OP_DIV:  return ChDiv;
        OP_POW:  return ChPow;
        default: return ChLParen;
      endcase
    endfunction

    // Characters that change state or produce output
    function bit is_meaningful(input logic [7:0] ch);
      op_code_e code;
      return is_operand(ch) || ch == ChLParen || ch == ChRParen ||
             oper_code(ch, code);
    endfunction

    function void emit(input logic [7:0] ch);
      postfix_q.push_back('{ch, 1'b1, 1'b0, 1'b0});
    endfunction

    function void pop_out();
      depth--;
      emit(code_char(op_stack[depth]));
    endfunction

    // Full stack drops the push and marks the expression
    function void push(input op_code_e code);
      if (depth >= StackDepth) begin
        ovf_seen = 1'b1;
      end else begin
        op_stack[depth] = code;
        depth++;
      end
    endfunction

    function void predict_postfix(input logic [7:0] ch, input logic eoe);
      int unsigned first;
      int unsigned idx;
      op_code_e    code;
      first = postfix_q.size();
      if (is_operand(ch)) begin
        emit(ch);
      end else if (ch == ChLParen) begin
        push(OP_LPAREN);
      end else if (ch == ChRParen) begin
        while (depth > 0 && op_stack[depth-1] != OP_LPAREN) pop_out();
        if (depth > 0) depth--;
      end else if (oper_code(ch, code)) begin
        // '^' is right-associative: only strictly higher rank pops
        while (depth > 0 && op_stack[depth-1] != OP_LPAREN &&
               ((code == OP_POW) ? rank(op_stack[depth-1]) > rank(code)
                                 : rank(op_stack[depth-1]) >= rank(code)))
          pop_out();
        push(code);
      end
      if (eoe) begin
        while (depth > 0) pop_out();
        if (postfix_q.size() == first) postfix_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
        idx = postfix_q.size() - 1;
        postfix_q[idx].last     = 1'b1;
        postfix_q[idx].overflow = ovf_seen;
        if (ovf_seen) n_ovf_exprs++;
        ovf_seen = 1'b0;
        n_exprs++;
      end
    endfunction

    function void check_emitted(input logic [7:0] ch, input logic lst,
                                input logic [1:0] user);
      postfix_item_t want;
      n_results++;
      if (postfix_q.size() == 0) begin
        $display("%0t: unexpected result ch=%h has=%b last=%b ovf=%b", $time,
                 ch, user[0], lst, user[1]);
        n_errors++;
        return;
      end
      want = postfix_q.pop_front();
      if (ch !== want.ch || user[0] !== want.has_char || lst !== want.last ||
          user[1] !== want.overflow) begin
        $write("%0t: result %0d mismatch: expected ch=%h has=%b last=%b ovf=%b",
               $time, n_results, want.ch, want.has_char, want.last, want.overflow);
        $display(", got ch=%h has=%b last=%b ovf=%b", ch, user[0], lst, user[1]);
        n_errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  postfix_tracker sb = new();
  logic [7:0]     expr_q[$];
  int unsigned    burst_left;
  int unsigned    n_sent;
  int unsigned    n_counted;

  infix_to_postfix #(
    .STACK_DEPTH(StackDepth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("infix_to_postfix regression: fail");
    $finish;
  end

  // Receiver: stall pattern changes mode after each random span
  initial begin : rx_pattern
    int unsigned mode;
    int unsigned span;
    m_axis_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = $urandom_range(0, 1);
          2:       m_axis_tready = ($urandom_range(0, 7) != 0);
          default: m_axis_tready = ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  // Result check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_emitted(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Send one character; the sender works in bursts with random gaps
  task automatic send_item(input logic [7:0] ch, input logic eoe);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    s_axis_tlast  = eoe;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_postfix(ch, eoe);
    n_sent++;
    if (sb.is_meaningful(ch)) n_counted++;
  endtask

  task automatic send_expr();
    if (expr_q.size() == 0) expr_q.push_back("q");
    foreach (expr_q[i]) send_item(expr_q[i], i == expr_q.size() - 1);
  endtask

  task automatic send_text(input string txt);
    expr_q.delete();
    for (int i = 0; i < txt.len(); i++) expr_q.push_back(txt[i]);
    send_expr();
  endtask

  // Hold off input until every pending result is out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.postfix_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range("A", "Z"));
      1:       return 8'($urandom_range("a", "z"));
      default: return 8'($urandom_range("0", "9"));
    endcase
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 4))
      0:       return ChAdd;
      1:       return ChSub;
      2:       return ChMul;
      3:       return ChDiv;
      default: return ChPow;
    endcase
  endfunction

  // Occasional spaces and junk bytes between tokens
  function automatic void add_char(input logic [7:0] ch);
    if ($urandom_range(0, 11) == 0) expr_q.push_back(" ");
    if ($urandom_range(0, 24) == 0) expr_q.push_back(8'($urandom_range(0, 255)));
    expr_q.push_back(ch);
  endfunction

  function automatic void gen_expr(input int unsigned lvl);
    int unsigned terms;
    terms = $urandom_range(1, 4);
    for (int unsigned t = 0; t < terms; t++) begin
      if (t != 0) add_char(rand_oper());
      if (lvl < 4 && $urandom_range(0, 3) == 0) begin
        add_char(ChLParen);
        gen_expr(lvl + 1);
        add_char(ChRParen);
      end else begin
        add_char(rand_operand());
      end
    end
  endfunction

  // Damage a well-formed expression
  function automatic void break_expr();
    int unsigned pos;
    pos = $urandom_range(0, expr_q.size() - 1);
    case ($urandom_range(0, 3))
      0:       expr_q.delete(pos);
      1:       expr_q.insert(pos, ChLParen);
      2:       expr_q.insert(pos, ChRParen);
      default: expr_q.insert(pos, 8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void gen_deep_nest(input int unsigned opens);
    int unsigned closes;
    expr_q.delete();
    repeat (opens) expr_q.push_back(ChLParen);
    expr_q.push_back(rand_operand());
    closes = $urandom_range(0, opens);
    repeat (closes) expr_q.push_back(ChRParen);
  endfunction

  function automatic void gen_pow_chain(input int unsigned ops);
    expr_q.delete();
    expr_q.push_back(rand_operand());
    repeat (ops) begin
      expr_q.push_back(ChPow);
      expr_q.push_back(rand_operand());
    end
  endfunction

  initial begin : stimulus
    int unsigned e;
    int unsigned wait_cnt;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    burst_left    = 0;
    n_sent        = 0;
    n_counted     = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: precedence, right-assoc power, stray parens, empty ends
    send_text("A-z+0*9");
    send_text("9^8^7/b");
    send_text("a+b)");
    send_text("(x");
    send_text(" ");
    expr_q.delete();
    expr_q.push_back(8'hFF);
    expr_q.push_back(8'h00);
    expr_q.push_back("~");
    send_expr();
    drain();

    // Random expressions, mostly well formed
    e = 0;
    while (n_sent < 230) begin
      if (e == 3) begin
        gen_pow_chain($urandom_range(StackDepth + 1, StackDepth + 3));
      end else if (e == 7) begin
        gen_deep_nest($urandom_range(StackDepth, StackDepth + 4));
      end else begin
        case ($urandom_range(0, 29))
          0:          gen_pow_chain($urandom_range(2, StackDepth + 2));
          1, 2:       gen_deep_nest($urandom_range(2, StackDepth + 4));
          3, 4, 5: begin
            expr_q.delete();
            gen_expr(0);
            break_expr();
          end
          default: begin
            expr_q.delete();
            gen_expr(0);
          end
        endcase
      end
      send_expr();
      if (e % 12 == 11) drain();
      e++;
    end

    // Let the last results out, then a margin for a trailing flush
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_cnt = 0;
    while (sb.postfix_q.size() != 0 && wait_cnt < 200_000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (64) @(negedge clk_i);
    if (sb.postfix_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.postfix_q.size());
      sb.n_errors++;
    end

    $display("Ran %0d expressions (%0d characters, %0d of them tokens), %0d with stack overflow;",
             sb.n_exprs, n_sent, n_counted, sb.n_ovf_exprs);
    $display("checked %0d postfix results, %0d mismatches.", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("infix_to_postfix regression: pass");
    end else begin
      $display("infix_to_postfix regression: fail");
    end
    $finish;
  end

endmodule
